[hw/rtl/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// Types and fixed constants shared by the scoped symbol table: item formats,
// operation and status codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned SCOPE_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned COUNT_W  = 7;

  // Operation codes; the three codes above cleanup are no-ops
  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE  = 3'd0,
    MODE_REFRESH = 3'd1,
    MODE_DELETE  = 3'd2,
    MODE_LOOKUP  = 3'd3,
    MODE_CLEANUP = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [HASH_W-1:0]  name_hash;
    logic [SCOPE_W-1:0] fn_scope;
    logic [SCOPE_W-1:0] ex_scope;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  removed;
    logic [COUNT_W-1:0]  live_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_op;     // capture the accepted item, restart the scan
    logic    issue;       // read the next slot
    logic    wr_entry;    // create: fill the slot in the stage
    logic    wr_escope;   // refresh: retag the slot in the stage
    logic    clr_valid;   // free the slot in the stage
    logic    res_set;     // capture the result
    status_e res_code;
    logic    res_slot_en; // result carries the stage slot
    logic    load_out;    // move the result to the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] op_mode;
    logic              pre_full;       // create refused before any scan
    logic              temp_match;
    logic              stage_vld;
    logic              stage_last;
    logic              stage_hit;
    logic              stage_free;
    logic              stage_clean;
    logic              stage_reserved;
    logic              none_removed;
  } stat_t;

endpackage

[hw/rtl/scoped_symbol_table.sv]
// ----------------------------------------------------------------------------
// scoped_symbol_table
// Fixed table of variable entries keyed by name hash and function scope,
// tagged with an execution scope. Create, refresh, delete, lookup, cleanup.
//
// Input channel in_valid_i / in_stall_o carries one operation item; the
// item is taken at a clock edge with valid high and stall low. Output
// channel out_valid_o / out_stall_i returns exactly one result item per
// operation, in order. temporary_hash is written through cfg_we_i and
// cfg_wdata_i while the block is idle; the user must keep to this, the
// block itself does not enforce it. Each operation walks the slots one
// per cycle through the single read port of the entry store. Delete and
// cleanup always walk the whole table. Create, refresh and lookup stop at
// the slot they act on, or at the last slot; a create refused on the live
// count and the spare codes finish before any scan. The next item can be
// taken in the cycle after the result enters the output register.
// A result waiting under stall is held; the next item may still be accepted
// and run, and its result waits until the held one is taken.
// Reset frees every slot, zeroes the live count and temporary_hash.
// ----------------------------------------------------------------------------
module scoped_symbol_table #(
  parameter int unsigned TABLE_DEPTH      = 64,
  parameter int unsigned UNRESERVED_DEPTH = 56
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sst_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sst_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i
);
  import sst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  sst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Table storage and scan datapath
  sst_datapath #(
    .TABLE_DEPTH      (TABLE_DEPTH),
    .UNRESERVED_DEPTH (UNRESERVED_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule

[hw/rtl/sst_datapath.sv]
// ----------------------------------------------------------------------------
// sst_datapath
// Entry store, valid bits, live count, slot scan pipeline, result and output
// registers. Reads one slot per cycle with a registered read; the slot in the
// stage register is evaluated and, on command, written back.
// ----------------------------------------------------------------------------
module sst_datapath #(
  parameter int unsigned TABLE_DEPTH      = 64,
  parameter int unsigned UNRESERVED_DEPTH = 56
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sst_pkg::in_item_t  in_item_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  sst_pkg::cmd_t      cmd_i,
  output sst_pkg::stat_t     stat_o,
  output sst_pkg::out_item_t out_item_o
);
  import sst_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Operation and configuration
  in_item_t           op_q;
  logic [HASH_W-1:0]  temp_hash_q;

  // Scan pipeline
  logic [CNT_W-1:0]   scan_q;
  logic               issue_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               stg_vld_q;
  logic [IDX_W-1:0]   stg_idx_q;
  logic               stg_ent_q;

  // Entry store
  logic [HASH_W-1:0]  hash_mem   [TABLE_DEPTH];
  logic [SCOPE_W-1:0] fscope_mem [TABLE_DEPTH];
  logic [SCOPE_W-1:0] escope_mem [TABLE_DEPTH];
  logic [HASH_W-1:0]  rd_hash_q;
  logic [SCOPE_W-1:0] rd_fscope_q;
  logic [SCOPE_W-1:0] rd_escope_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  // Counts and result
  logic [CNT_W-1:0]   live_q;
  logic [CNT_W-1:0]   removed_q;
  status_e            res_status_q;
  logic [SLOT_W-1:0]  res_slot_q;
  out_item_t          out_q;

  assign issue_en = cmd_i.issue && (32'(scan_q) < 32'(TABLE_DEPTH));
  assign rd_addr  = scan_q[IDX_W-1:0];

  // Captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      op_q <= in_item_i;
    end
  end

  // Temporary hash register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_hash_q <= '0;
    end else if (cfg_we_i) begin
      temp_hash_q <= cfg_wdata_i;
    end
  end

  // Scan counter and stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      stg_vld_q <= 1'b0;
      stg_idx_q <= '0;
      stg_ent_q <= 1'b0;
    end else if (cmd_i.load_op) begin
      scan_q    <= '0;
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= issue_en;
      if (issue_en) begin
        scan_q    <= scan_q + CNT_W'(1);
        stg_idx_q <= rd_addr;
        stg_ent_q <= valid_q[rd_addr];
      end
    end
  end

  // Entry store: one write port at the stage slot, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      hash_mem[stg_idx_q]   <= op_q.name_hash;
      fscope_mem[stg_idx_q] <= op_q.fn_scope;
    end
    if (cmd_i.wr_entry || cmd_i.wr_escope) begin
      escope_mem[stg_idx_q] <= op_q.ex_scope;
    end
    if (issue_en) begin
      rd_hash_q   <= hash_mem[rd_addr];
      rd_fscope_q <= fscope_mem[rd_addr];
      rd_escope_q <= escope_mem[rd_addr];
    end
  end

  // Valid bits, live count, removed count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      live_q    <= '0;
      removed_q <= '0;
    end else begin
      if (cmd_i.wr_entry) begin
        valid_q[stg_idx_q] <= 1'b1;
        live_q             <= live_q + CNT_W'(1);
      end else if (cmd_i.clr_valid) begin
        valid_q[stg_idx_q] <= 1'b0;
        if (live_q != '0) begin
          live_q <= live_q - CNT_W'(1);
        end
      end
      if (cmd_i.load_op) begin
        removed_q <= '0;
      end else if (cmd_i.clr_valid) begin
        removed_q <= removed_q + CNT_W'(1);
      end
    end
  end

  // Result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_slot_q   <= cmd_i.res_slot_en ? SLOT_W'(stg_idx_q) : '0;
    end
    if (cmd_i.load_out) begin
      out_q.status     <= res_status_q;
      out_q.slot       <= res_slot_q;
      out_q.removed    <= COUNT_W'(removed_q);
      out_q.live_count <= COUNT_W'(live_q);
    end
  end

  // Status towards the controller
  always_comb begin
    stat_o.op_mode        = op_q.mode;
    stat_o.temp_match     = (op_q.name_hash == temp_hash_q);
    stat_o.pre_full       = (32'(live_q) >= 32'(UNRESERVED_DEPTH)) &&
                            (!stat_o.temp_match || (32'(live_q) >= 32'(TABLE_DEPTH)));
    stat_o.stage_vld      = stg_vld_q;
    stat_o.stage_last     = (32'(stg_idx_q) == 32'(TABLE_DEPTH - 1));
    stat_o.stage_hit      = stg_ent_q && (rd_hash_q == op_q.name_hash) &&
                            (rd_fscope_q == op_q.fn_scope);
    stat_o.stage_free     = !stg_ent_q;
    stat_o.stage_clean    = stg_ent_q && ((op_q.ex_scope == '0) ||
                            (rd_escope_q > op_q.ex_scope));
    stat_o.stage_reserved = (32'(stg_idx_q) >= 32'(UNRESERVED_DEPTH));
    stat_o.none_removed   = (removed_q == '0);
  end

  assign out_item_o = out_q;

endmodule

[hw/rtl/sst_ctrl.sv]
// ----------------------------------------------------------------------------
// sst_ctrl
// Operation sequencer: accepts an item, steps the slot scan, decides per
// scanned slot what the operation does to it, and hands the result to the
// output register.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sst_pkg::cmd_t  cmd_o,
  input  sst_pkg::stat_t stat_i
);
  import sst_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   finish;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (finish) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (cmd_o.load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and per-slot decisions
  always_comb begin
    cmd_o       = '0;
    cmd_o.res_code = ST_OK;
    finish      = 1'b0;
    in_stall_o  = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        cmd_o.load_op = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        case (stat_i.op_mode)
          MODE_CREATE: begin
            if (stat_i.pre_full) begin
              finish         = 1'b1;
              cmd_o.res_code = ST_FULL;
            end else if (stat_i.stage_vld && stat_i.stage_free) begin
              finish = 1'b1;
              if (stat_i.stage_reserved && !stat_i.temp_match) begin
                cmd_o.res_code = ST_FULL;
              end else begin
                cmd_o.wr_entry    = 1'b1;
                cmd_o.res_slot_en = 1'b1;
              end
            end else if (stat_i.stage_vld && stat_i.stage_last) begin
              finish         = 1'b1;
              cmd_o.res_code = ST_FULL;
            end
          end
          MODE_REFRESH, MODE_LOOKUP: begin
            if (stat_i.stage_vld && stat_i.stage_hit) begin
              finish            = 1'b1;
              cmd_o.res_slot_en = 1'b1;
              cmd_o.wr_escope   = (stat_i.op_mode == MODE_REFRESH);
            end else if (stat_i.stage_vld && stat_i.stage_last) begin
              finish         = 1'b1;
              cmd_o.res_code = ST_NO_MATCH;
            end
          end
          MODE_DELETE: begin
            if (stat_i.stage_vld) begin
              cmd_o.clr_valid = stat_i.stage_hit;
              if (stat_i.stage_last) begin
                finish = 1'b1;
                if (stat_i.none_removed && !stat_i.stage_hit) begin
                  cmd_o.res_code = ST_NO_MATCH;
                end
              end
            end
          end
          MODE_CLEANUP: begin
            if (stat_i.stage_vld) begin
              cmd_o.clr_valid = stat_i.stage_clean;
              finish          = stat_i.stage_last;
            end
          end
          default: begin
            // unused codes do nothing
            finish = 1'b1;
          end
        endcase
        cmd_o.res_set = finish;
      end
      S_FINISH: begin
        cmd_o.load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // An accepted item always starts a scan
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_SCAN))
    else $error("accepted item did not start a scan");

  // Table writes only act on a live stage slot during a scan
  a_write_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_entry || cmd_o.wr_escope || cmd_o.clr_valid) |->
      (state_q == S_SCAN && stat_i.stage_vld))
    else $error("table write outside a scanned slot");

  // Each operation ends with exactly one result handed on
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && cmd_o.load_out) |=> (state_q == S_IDLE && out_valid_q))
    else $error("result not delivered after finish");

endmodule
